[rtl/dbd_pkg.sv]
package dbd_pkg;

    localparam int DATE_W  = 27;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int DNUM_W  = 23;

    // floor(v / 10000) = (v * YEAR_RECIP) >> YEAR_SHIFT, exact for v < 2**27
    localparam logic [27:0] YEAR_RECIP = 28'd219902326;
    localparam int          YEAR_SHIFT = 41;
    // floor(r / 100) = (r * MON_RECIP) >> 20, exact for r < 10000
    localparam logic [13:0] MON_RECIP  = 14'd10486;
    // floor(y / 100) = (y * CENT_RECIP) >> 21, exact for y < 2**14
    localparam logic [14:0] CENT_RECIP = 15'd20972;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [8:0] DAYS_BEFORE [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
    };

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic              leap;
        logic [11:0]       leaps;   // leap years before this year
    } date_t;

    typedef struct packed {
        logic  bad;
        date_t lo;
        date_t hi;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/dbd_front.sv]
module dbd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          date_valid,
    output logic                          date_stall,
    input  logic [dbd_pkg::DATE_W-1:0]    first_date,
    input  logic [dbd_pkg::DATE_W-1:0]    second_date,
    output dbd_pkg::push_t                push,
    input  logic                          q_full
);
    import dbd_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_YEAR  = 6'b000010,
        F_REM   = 6'b000100,
        F_MON   = 6'b001000,
        F_DAY   = 6'b010000,
        F_CHECK = 6'b100000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [DATE_W-1:0] v_reg    [2];
    logic [YEAR_W-1:0] y_reg    [2];
    logic [13:0]       r_reg    [2];
    logic [6:0]        m_reg    [2];
    logic [6:0]        d_reg    [2];
    logic [7:0]        q100_reg [2];
    logic [6:0]        r100_reg [2];

    logic accept;
    logic [54:0] year_prod [2];
    logic [27:0] mon_prod  [2];
    logic [28:0] cent_prod [2];
    logic [26:0] rem_full  [2];
    logic [13:0] day_full  [2];
    logic [7:0]  cent_full [2];
    logic        ok        [2];
    date_t       dt        [2];

    assign accept     = date_valid && (state_reg == F_IDLE);
    assign date_stall = (state_reg != F_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (date_valid) state_next = F_YEAR;
            F_YEAR:  state_next = F_REM;
            F_REM:   state_next = F_MON;
            F_MON:   state_next = F_DAY;
            F_DAY:   state_next = F_CHECK;
            F_CHECK: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            year_prod[i] = 55'(v_reg[i]) * 55'(YEAR_RECIP);
            rem_full[i]  = v_reg[i] - 27'(y_reg[i]) * 27'd10000;
            mon_prod[i]  = 28'(r_reg[i]) * 28'(MON_RECIP);
            cent_prod[i] = 29'(y_reg[i]) * 29'(CENT_RECIP);
            day_full[i]  = r_reg[i] - 14'(m_reg[i]) * 14'd100;
            cent_full[i] = 8'(y_reg[i] - 14'(q100_reg[i]) * 14'd100);
        end
    end

    // ordering, year, remainder/century, month/century remainder, day
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
                if (accept)
                begin
                    v_reg[0] <= (first_date > second_date) ? second_date : first_date;
                    v_reg[1] <= (first_date > second_date) ? first_date : second_date;
                end
            F_YEAR:
                for (int i = 0; i < 2; i++)
                    y_reg[i] <= year_prod[i][54:YEAR_SHIFT];
            F_REM:
                for (int i = 0; i < 2; i++)
                begin
                    r_reg[i]    <= rem_full[i][13:0];
                    q100_reg[i] <= cent_prod[i][28:21];
                end
            F_MON:
                for (int i = 0; i < 2; i++)
                begin
                    m_reg[i]    <= mon_prod[i][26:20];
                    r100_reg[i] <= cent_full[i][6:0];
                end
            F_DAY:
                for (int i = 0; i < 2; i++)
                    d_reg[i] <= day_full[i][6:0];
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            logic [7:0]  c100;
            logic [7:0]  c400;
            logic [12:0] c4;
            logic [12:0] lsum;
            logic [4:0]  lim;
            logic        lp;
            lp   = ((y_reg[i][1:0] == 2'd0) && (r100_reg[i] != 7'd0))
                || ((r100_reg[i] == 7'd0) && (q100_reg[i][1:0] == 2'd0));
            c100 = q100_reg[i] + 8'(r100_reg[i] != 7'd0);
            c400 = 8'((9'(c100) + 9'd3) >> 2);
            c4   = 13'((15'(y_reg[i]) + 15'd3) >> 2);
            lsum = c4 - 13'(c100) + 13'(c400);
            lim  = (m_reg[i] == 7'd2 && lp) ? 5'd29 : month_len(m_reg[i][3:0]);
            ok[i] = (m_reg[i] >= 7'd1) && (m_reg[i] <= 7'd12) && (d_reg[i] != 7'd0)
                 && (d_reg[i] <= 7'(lim));
            dt[i].year  = y_reg[i];
            dt[i].month = m_reg[i][3:0];
            dt[i].day   = d_reg[i][4:0];
            dt[i].leap  = lp;
            dt[i].leaps = lsum[11:0];
        end
    end

    assign push.valid    = (state_reg == F_CHECK) && !q_full;
    assign push.item.bad = !(ok[0] && ok[1]);
    assign push.item.lo  = dt[0];
    assign push.item.hi  = dt[1];

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (date_valid && !date_stall) |=> (state_reg == F_YEAR))
        else $error("front did not start after a transfer");

endmodule

[rtl/dbd_fifo.sv]
module dbd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  dbd_pkg::push_t  push,
    output logic            full,
    input  logic            pop,
    output dbd_pkg::item_t  pop_item,
    output logic            empty
);
    import dbd_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push.valid) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

endmodule

[rtl/dbd_back.sv]
module dbd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  dbd_pkg::item_t                q_item,
    output logic                          pop,
    output logic                          span_valid,
    input  logic                          span_stall,
    output logic [dbd_pkg::COUNT_W-1:0]   day_count,
    output logic                          bad_date
);
    import dbd_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_NUM  = 3'b010,
        B_SPAN = 3'b100
    } bstate_t;

    bstate_t state_reg, state_next;

    item_t              item_reg;
    logic [DNUM_W-1:0]  nlo_reg, nhi_reg;
    logic               span_valid_reg;
    logic [COUNT_W-1:0] day_count_reg;
    logic               bad_reg;

    logic               out_free;
    logic [DNUM_W:0]    span;
    logic [COUNT_W-1:0] span_sat;

    function automatic logic [DNUM_W-1:0] day_num(input date_t dt);
        return DNUM_W'(dt.year) * DNUM_W'(365) + DNUM_W'(dt.leaps)
             + DNUM_W'(DAYS_BEFORE[dt.month]) + DNUM_W'(dt.day)
             + DNUM_W'((dt.month > 4'd2) && dt.leap);
    endfunction

    assign out_free = !span_valid_reg || !span_stall;
    assign pop      = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!q_empty) state_next = B_NUM;
            B_NUM:   state_next = B_SPAN;
            B_SPAN:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // dates are ordered by packed value, so nhi >= nlo for any good pair
    always_comb
    begin
        if (nhi_reg >= nlo_reg)
            span = {1'b0, nhi_reg} - {1'b0, nlo_reg} + (DNUM_W+1)'(1);
        else
            span = (DNUM_W+1)'(1);
        span_sat = (span > (DNUM_W+1)'(COUNT_MAX)) ? COUNT_MAX : span[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_SPAN && out_free)
                span_valid_reg <= 1'b1;
            else if (!span_stall)
                span_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_item;
        if (state_reg == B_NUM)
        begin
            nlo_reg <= day_num(item_reg.lo);
            nhi_reg <= day_num(item_reg.hi);
        end
        if (state_reg == B_SPAN && out_free)
        begin
            bad_reg       <= item_reg.bad;
            day_count_reg <= item_reg.bad ? '0 : span_sat;
        end
    end

    assign span_valid = span_valid_reg;
    assign day_count  = day_count_reg;
    assign bad_date   = bad_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (span_valid_reg && bad_reg) |-> (day_count_reg == '0))
        else $error("bad date with nonzero count");

endmodule

[rtl/days_between_dates.sv]
// channel  | transfer when          | fields
// ---------+------------------------+---------------------------------
// date     | date_valid & !date_stall | first_date[26:0], second_date[26:0]
// span     | span_valid & !span_stall | day_count[21:0], bad_date
//
// Front takes one date pair at a time, date_stall high until done: order,
// divide-by-10000, remainder, divide-by-100, day, one registered step each
// for both dates, then validate and push to the queue. Back pops a pair,
// then registers its day numbers and span; a 2-entry queue sits between
// them, and the output register holds a result while span_stall.
// Reset clears only control state; no memory clearing is needed.
module days_between_dates (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          date_valid,
    output logic                          date_stall,
    input  logic [dbd_pkg::DATE_W-1:0]    first_date,
    input  logic [dbd_pkg::DATE_W-1:0]    second_date,
    output logic                          span_valid,
    input  logic                          span_stall,
    output logic [dbd_pkg::COUNT_W-1:0]   day_count,
    output logic                          bad_date
);
    import dbd_pkg::*;

    push_t push;
    item_t q_item;
    logic  q_full, q_empty, pop;

    dbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .date_valid  (date_valid),
        .date_stall  (date_stall),
        .first_date  (first_date),
        .second_date (second_date),
        .push        (push),
        .q_full      (q_full)
    );

    dbd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (q_full),
        .pop      (pop),
        .pop_item (q_item),
        .empty    (q_empty)
    );

    dbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (q_item),
        .pop        (pop),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .day_count  (day_count),
        .bad_date   (bad_date)
    );

endmodule
